[hw/rtl/dual_stack_shared_buffer_macros.svh]
// Assertion macros shared by the dual stack buffer RTL.
`ifndef DUAL_STACK_SHARED_BUFFER_MACROS_SVH
`define DUAL_STACK_SHARED_BUFFER_MACROS_SVH

// Check cons in the same cycle as ante; clk_i and rst_ni must be in scope.
`define DSB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define DSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dsb_pkg.sv]
// Constants, types and helper functions of the dual stack buffer.
package dsb_pkg;

  localparam int unsigned BUFFER_DEPTH  = 1024;
  localparam int unsigned ELEMENT_WIDTH = 32;
  localparam int unsigned ADDR_W        = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W         = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CFG_W         = 11;
  localparam int unsigned DATA_W        = 32;

  localparam logic [CFG_W-1:0]  CAP_RESET    = CFG_W'(1024);
  localparam logic [DATA_W-1:0] EMPTY_MARKER = DATA_W'(100000000);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;
  localparam logic SEL_LOW   = 1'b0;
  localparam logic SEL_HIGH  = 1'b1;

  typedef struct packed {
    logic latch_req;
    logic execute;
    logic load_rd;
    logic cfg_wr;
  } cmd_t;

  typedef struct packed {
    logic req_pop;
    logic req_fail;
  } stat_t;

  // Capacity in force: written value clamped to [1, BUFFER_DEPTH].
  function automatic logic [CNT_W-1:0] cap_clamp(input logic [CFG_W-1:0] v);
    int unsigned c;
    c = 32'(v);
    if (c < 1) c = 1;
    if (c > BUFFER_DEPTH) c = BUFFER_DEPTH;
    return CNT_W'(c);
  endfunction

  function automatic logic [ELEMENT_WIDTH-1:0] to_elem(input logic [DATA_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[ELEMENT_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] from_elem(input logic [ELEMENT_WIDTH-1:0] e);
    logic [63:0] w;
    w = 64'(e);
    return w[DATA_W-1:0];
  endfunction

endpackage

[hw/rtl/dual_stack_shared_buffer.sv]
// A request is latched in S_IDLE; a push or a failed request loads its result and sets result valid in S_EXEC,
// a successful pop issues the RAM read in S_EXEC and loads the registered read data in S_READ.
// Only one request is in flight: the single-request sequencer and the read register of the shared RAM
// keep a new request out until the current one has loaded its result;
// a stalled result holds the sequencer, and with it the input, until it is taken.
// Reset: both stacks empty, capacity 1024; RAM contents stay undefined, no clear pass.
module dual_stack_shared_buffer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic                              stack_select_i,
  input  logic signed [dsb_pkg::DATA_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [dsb_pkg::DATA_W-1:0] popped_value_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dsb_pkg::CFG_W-1:0]         capacity_in_use_i
);

  dsb_pkg::cmd_t  cmd;
  dsb_pkg::stat_t stat;

  dsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsb_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mode_i            (mode_i),
    .stack_select_i    (stack_select_i),
    .push_value_i      (push_value_i),
    .capacity_in_use_i (capacity_in_use_i),
    .status_o          (status_o),
    .popped_value_o    (popped_value_o)
  );

endmodule

[hw/rtl/dsb_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module dsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dsb_dp.sv]
// Datapath: request register, stack counts, capacity, shared RAM and result register.
`include "dual_stack_shared_buffer_macros.svh"

module dsb_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dsb_pkg::cmd_t                    cmd_i,
  output dsb_pkg::stat_t                   stat_o,
  input  logic                             mode_i,
  input  logic                             stack_select_i,
  input  logic signed [dsb_pkg::DATA_W-1:0] push_value_i,
  input  logic [dsb_pkg::CFG_W-1:0]        capacity_in_use_i,
  output logic [1:0]                       status_o,
  output logic signed [dsb_pkg::DATA_W-1:0] popped_value_o
);

  logic                             mode_q;
  logic                             sel_q;
  logic [dsb_pkg::DATA_W-1:0]       value_q;
  logic [dsb_pkg::CNT_W-1:0]        low_q, low_d;
  logic [dsb_pkg::CNT_W-1:0]        high_q, high_d;
  logic [dsb_pkg::CNT_W-1:0]        cap_q, cap_d;
  logic [1:0]                       status_q;
  logic [dsb_pkg::DATA_W-1:0]       data_q;

  logic [dsb_pkg::CNT_W:0]          used;
  logic [dsb_pkg::CNT_W:0]          cap_ext;
  logic                             full;
  logic                             empty;
  logic                             is_pop;
  logic                             fail;
  logic [dsb_pkg::CNT_W-1:0]        hi_base;
  logic [dsb_pkg::CNT_W-1:0]        slot;
  logic                             ram_we;
  logic                             ram_re;
  logic [dsb_pkg::ELEMENT_WIDTH-1:0] ram_rdata;

  assign used    = {1'b0, low_q} + {1'b0, high_q};
  assign cap_ext = {1'b0, cap_q};
  assign full    = used >= cap_ext;
  assign empty   = (sel_q == dsb_pkg::SEL_LOW) ? (low_q == '0) : (high_q == '0);
  assign is_pop  = (mode_q == dsb_pkg::MODE_POP);
  assign fail    = is_pop ? empty : full;
  assign hi_base = cap_q - high_q;

  // Push writes the next free entry; pop reads the current top.
  always_comb begin
    if (sel_q == dsb_pkg::SEL_LOW) begin
      slot = is_pop ? (low_q - dsb_pkg::CNT_W'(1)) : low_q;
    end else begin
      slot = is_pop ? hi_base : (hi_base - dsb_pkg::CNT_W'(1));
    end
  end

  assign ram_we = cmd_i.execute && !is_pop && !fail;
  assign ram_re = cmd_i.execute && is_pop && !fail;

  assign stat_o.req_pop  = is_pop;
  assign stat_o.req_fail = fail;

  dsb_ram #(
    .WIDTH (dsb_pkg::ELEMENT_WIDTH),
    .DEPTH (dsb_pkg::BUFFER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot[dsb_pkg::ADDR_W-1:0]),
    .wdata_i (dsb_pkg::to_elem(value_q)),
    .re_i    (ram_re),
    .raddr_i (slot[dsb_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    cap_d  = cap_q;
    if (cmd_i.cfg_wr) begin
      cap_d  = dsb_pkg::cap_clamp(capacity_in_use_i);
      low_d  = '0;
      high_d = '0;
    end else if (cmd_i.execute && !fail) begin
      if (sel_q == dsb_pkg::SEL_LOW) begin
        low_d = is_pop ? (low_q - dsb_pkg::CNT_W'(1)) : (low_q + dsb_pkg::CNT_W'(1));
      end else begin
        high_d = is_pop ? (high_q - dsb_pkg::CNT_W'(1)) : (high_q + dsb_pkg::CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
      cap_q  <= dsb_pkg::cap_clamp(dsb_pkg::CAP_RESET);
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
      cap_q  <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      mode_q  <= mode_i;
      sel_q   <= stack_select_i;
      value_q <= push_value_i;
    end
    if (cmd_i.load_rd) begin
      status_q <= dsb_pkg::ST_OK;
      data_q   <= dsb_pkg::from_elem(ram_rdata);
    end else if (cmd_i.execute && !(is_pop && !fail)) begin
      if (!fail) begin
        status_q <= dsb_pkg::ST_OK;
        data_q   <= '0;
      end else if (is_pop) begin
        status_q <= dsb_pkg::ST_EMPTY;
        data_q   <= dsb_pkg::EMPTY_MARKER;
      end else begin
        status_q <= dsb_pkg::ST_FULL;
        data_q   <= '0;
      end
    end
  end

  assign status_o       = status_q;
  assign popped_value_o = data_q;

  `DSB_ASSERT_SAME(a_within_capacity, 1'b1, used <= cap_ext, "stacks overrun capacity")
  `DSB_ASSERT_NEXT(a_cfg_empties, cmd_i.cfg_wr, (low_q == '0) && (high_q == '0), "config left data")
  `DSB_ASSERT_SAME(a_cfg_idle, cmd_i.cfg_wr, !cmd_i.execute, "config write during a request")

endmodule

[hw/rtl/dsb_ctrl.sv]
// Controller: sequences one request through execute and RAM read, owns result valid.
`include "dual_stack_shared_buffer_macros.svh"

module dsb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  dsb_pkg::stat_t stat_i,
  output dsb_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       rd_pending;
  logic       load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_pending = stat_i.req_pop && !stat_i.req_fail;

  assign in_stall_o   = (state_q != S_IDLE);
  assign cfg_ready_o  = (state_q == S_IDLE);
  assign cmd_o.cfg_wr = cfg_valid_i && cfg_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o.latch_req = 1'b0;
    cmd_o.execute   = 1'b0;
    cmd_o.load_rd   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        // a successful pop only issues the read; others load the result once the output is free
        if (rd_pending) begin
          cmd_o.execute = 1'b1;
          state_d       = S_READ;
        end else if (out_free) begin
          cmd_o.execute = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd_o.load_rd = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign load = (cmd_o.execute && !rd_pending) || cmd_o.load_rd;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DSB_ASSERT_SAME(a_load_when_free, load, out_free, "result loaded over a pending one")
  `DSB_ASSERT_NEXT(a_pop_reads, (state_q == S_EXEC) && rd_pending, state_q == S_READ, "pop skipped read")
  `DSB_ASSERT_SAME(a_result_after_work, $rose(out_valid_q), $past(state_q) != S_IDLE, "result without request")

endmodule
